// ----- design/pms_pkg.sv -----
`default_nettype none

package pms_pkg;

  // Request codes on func; code 3 is treated like no request
  localparam logic [1:0] FUNC_NONE  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;

  // Completion status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_MASTER_ABORT = 3'd1;
  localparam logic [2:0] ST_TARGET_ABORT = 3'd2;
  localparam logic [2:0] ST_TRDY_TIMEOUT = 3'd3;
  localparam logic [2:0] ST_RETRY        = 3'd4;
  localparam logic [2:0] ST_PARITY_ERR   = 3'd5;
  localparam logic [2:0] ST_BUS_ERR      = 3'd6;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVSEL_TO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRDY_TO   = 2'd1;

  localparam logic [3:0]  DEVSEL_TO_RST = 4'd4;
  localparam logic [3:0]  TRDY_TO_RST   = 4'd12;
  localparam logic [31:0] ALL_ONES      = 32'hffff_ffff;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SETUP,
    PH_DEVSEL,
    PH_TRDY,
    PH_POST,
    PH_ABORT_M,
    PH_ABORT_T
  } phase_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] address;
    logic [3:0]  command;
    logic [3:0]  byte_enables;
    logic [31:0] write_data;
    logic        devsel_seen;
    logic        trdy_seen;
    logic        stop_seen;
    logic        bus_busy_seen;
    logic [31:0] ad_sampled;
    logic        par_sampled;
  } req_t;

  typedef struct packed {
    logic        frame_drive;
    logic        irdy_drive;
    logic [31:0] ad_out;
    logic        ad_enable;
    logic [3:0]  cbe_out;
    logic        cbe_enable;
    logic        par_out;
    logic        par_enable;
    logic        done_res;
    logic [2:0]  status;
    logic [31:0] read_data;
  } res_t;

  typedef struct packed {
    logic [3:0] devsel_timeout;
    logic [3:0] trdy_timeout;
  } cfg_t;

  // Even parity over AD and C/BE
  function automatic logic even_par(logic [31:0] word, logic [3:0] nib);
    return (^word) ^ (^nib);
  endfunction

  // A zero timeout behaves as one
  function automatic logic [3:0] nonzero(logic [3:0] t);
    return (t == 4'd0) ? 4'd1 : t;
  endfunction

endpackage

`default_nettype wire

// ----- design/pms_cfg.sv -----
`default_nettype none

module pms_cfg import pms_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [3:0]           cfg_data_i,
  output cfg_t                      cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == CFG_DEVSEL_TO) begin
        cfg_d.devsel_timeout = cfg_data_i;
      end else if (cfg_index_i == CFG_TRDY_TO) begin
        cfg_d.trdy_timeout = cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.devsel_timeout <= DEVSEL_TO_RST;
      cfg_q.trdy_timeout   <= TRDY_TO_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- design/pms_fsm.sv -----
`default_nettype none

module pms_fsm import pms_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic step_i,
  input  wire req_t req_i,
  input  wire cfg_t cfg_i,
  output res_t      res_o
);

  phase_e      phase_q, phase_d;
  logic [3:0]  wait_q, wait_d;
  logic        wr_q, wr_d;
  logic [3:0]  be_q, be_d;
  logic [31:0] data_q, data_d;
  logic        apar_q, apar_d;

  logic        dpar;
  logic [3:0]  wait_eff;
  logic [3:0]  wait_dec;
  logic        is_req;

  assign dpar     = even_par(data_q, be_q);
  assign is_req   = (req_i.func == FUNC_READ) || (req_i.func == FUNC_WRITE);
  // DEVSEL seen in the DEVSEL phase: TRDY is checked on the same request
  assign wait_eff = (phase_q == PH_DEVSEL) ? nonzero(cfg_i.trdy_timeout) : wait_q;

  // Next state and latched transfer data
  always_comb begin
    phase_d = phase_q;
    wait_d  = wait_q;
    wr_d    = wr_q;
    be_d    = be_q;
    data_d  = data_q;
    apar_d  = apar_q;
    wait_dec = 4'd0;
    unique case (phase_q)
      PH_IDLE: begin
        if (is_req && !req_i.bus_busy_seen) begin
          wr_d    = (req_i.func == FUNC_WRITE);
          be_d    = req_i.byte_enables;
          data_d  = (req_i.func == FUNC_WRITE) ? req_i.write_data : 32'd0;
          apar_d  = even_par(req_i.address, req_i.command);
          phase_d = PH_SETUP;
        end
      end
      PH_SETUP: begin
        wait_d  = nonzero(cfg_i.devsel_timeout);
        phase_d = PH_DEVSEL;
      end
      PH_DEVSEL, PH_TRDY: begin
        if (phase_q == PH_DEVSEL && !req_i.devsel_seen) begin
          wait_dec = wait_q - 4'd1;
          wait_d   = wait_dec;
          if (wait_dec == 4'd0) begin
            phase_d = PH_ABORT_M;
          end
        end else if (req_i.trdy_seen) begin
          wait_d = wait_eff;
          if (!wr_q) begin
            data_d = req_i.ad_sampled;
          end
          phase_d = PH_POST;
        end else if (req_i.stop_seen) begin
          wait_d  = wait_eff;
          phase_d = PH_IDLE;
        end else begin
          wait_dec = wait_eff - 4'd1;
          wait_d   = wait_dec;
          phase_d  = (wait_dec == 4'd0) ? PH_ABORT_T : PH_TRDY;
        end
      end
      PH_POST, PH_ABORT_M, PH_ABORT_T: begin
        phase_d = PH_IDLE;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  // Bus drive and completion for this clock
  always_comb begin
    res_o = '0;
    unique case (phase_q)
      PH_IDLE: begin
        if (is_req) begin
          if (req_i.bus_busy_seen) begin
            res_o.done_res  = 1'b1;
            res_o.status    = ST_BUS_ERR;
            res_o.read_data = ALL_ONES;
          end else begin
            res_o.frame_drive = 1'b1;
            res_o.ad_out      = req_i.address;
            res_o.ad_enable   = 1'b1;
            res_o.cbe_out     = req_i.command;
            res_o.cbe_enable  = 1'b1;
          end
        end
      end
      PH_SETUP: begin
        res_o.irdy_drive = 1'b1;
        res_o.ad_out     = wr_q ? data_q : 32'd0;
        res_o.ad_enable  = wr_q;
        res_o.cbe_out    = be_q;
        res_o.cbe_enable = 1'b1;
        res_o.par_out    = apar_q;
        res_o.par_enable = 1'b1;
      end
      PH_DEVSEL, PH_TRDY: begin
        if ((phase_q == PH_DEVSEL && !req_i.devsel_seen)
            || (!req_i.trdy_seen && !req_i.stop_seen)) begin
          // wait clock: IRDY on, data or turnaround on AD
          res_o.irdy_drive = 1'b1;
          res_o.ad_out     = wr_q ? data_q : 32'd0;
          res_o.ad_enable  = wr_q;
          res_o.cbe_out    = be_q;
          res_o.cbe_enable = 1'b1;
          res_o.par_out    = wr_q & dpar;
          res_o.par_enable = wr_q;
        end else if (req_i.trdy_seen) begin
          res_o.par_out    = wr_q & dpar;
          res_o.par_enable = wr_q;
        end else begin
          // STOP without TRDY: retry if DEVSEL, else target abort
          res_o.done_res  = 1'b1;
          res_o.status    = req_i.devsel_seen ? ST_RETRY : ST_TARGET_ABORT;
          res_o.read_data = ALL_ONES;
        end
      end
      PH_POST: begin
        res_o.done_res = 1'b1;
        if (wr_q) begin
          res_o.status = ST_OK;
        end else begin
          res_o.read_data = data_q;
          res_o.status    = (req_i.par_sampled != dpar) ? ST_PARITY_ERR : ST_OK;
        end
      end
      PH_ABORT_M: begin
        res_o.done_res  = 1'b1;
        res_o.status    = ST_MASTER_ABORT;
        res_o.read_data = ALL_ONES;
      end
      PH_ABORT_T: begin
        res_o.done_res  = 1'b1;
        res_o.status    = ST_TRDY_TIMEOUT;
        res_o.read_data = ALL_ONES;
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      wait_q  <= 4'd0;
      wr_q    <= 1'b0;
      be_q    <= 4'd0;
      data_q  <= 32'd0;
      apar_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      wait_q  <= wait_d;
      wr_q    <= wr_d;
      be_q    <= be_d;
      data_q  <= data_d;
      apar_q  <= apar_d;
    end
  end

  // done and status only go together
  a_idle_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !res_o.done_res) |-> (res_o.status == ST_OK && res_o.read_data == 32'd0))
    else $error("status or read data without completion");

  // a released AD bus carries zero
  a_ad_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !res_o.ad_enable) |-> res_o.ad_out == 32'd0)
    else $error("AD value while released");

  // wait counter never runs out while waiting
  a_wait_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DEVSEL || phase_q == PH_TRDY) |-> wait_q != 4'd0)
    else $error("wait counter zero in a wait phase");

  // abort phases finish in one step
  a_abort_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (phase_q == PH_ABORT_M || phase_q == PH_ABORT_T))
      |=> phase_q == PH_IDLE)
    else $error("abort phase did not return to idle");

endmodule

`default_nettype wire

// ----- design/pci_master_single_transfer.sv -----
`default_nettype none

// PCI initiator for single-data-phase reads and writes, one request per PCI clock.
// Input channel (in_valid_i/in_ready_o, in_req_i): each request is one bus clock:
//   the transfer request (used only while idle) plus DEVSEL, TRDY, STOP, busy,
//   AD and PAR as sampled at that clock.
// Output channel (out_valid_o/out_ready_i, out_res_o): one result per request with
//   FRAME/IRDY drive, AD/C/BE/PAR values and enables, and done/status/read data.
// Config channel (cfg_valid_i/cfg_ready_o): index 0 DEVSEL timeout, index 1
//   TRDY timeout, 4 bits each; always ready. Write only while no transfer runs.
// Path: a request is held in the input register, passes once through the phase
//   logic, and its result is stored in the result register.
// Throughput: one request per clock when not stalled; the phase logic steps once per request.
// Stall: when the receiver holds off, the result register keeps its value, the
//   input register fills and in_ready_o drops until the result is taken.
// Reset: phase idle, no requests held, timeouts 4 and 12.

module pci_master_single_transfer import pms_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire req_t                 in_req_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output res_t                      out_res_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [3:0]           cfg_data_i
);

  logic in_vld_q, in_vld_d;
  req_t in_req_q;
  logic out_vld_q, out_vld_d;
  res_t out_res_q;
  res_t res_d;
  cfg_t cfg;
  logic step;

  // a held request steps when the result register is free or draining
  assign step       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || step;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_valid_i && in_ready_o) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (step) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_req_q <= in_req_i;
    end
    if (step) begin
      out_res_q <= res_d;
    end
  end

  pms_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pms_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .req_i  (in_req_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_res_q;

endmodule

`default_nettype wire

// ----- bench/pci_master_single_transfer_tb.sv -----
module pci_master_single_transfer_tb;
  import pms_pkg::*;

  // Request code 3 is not defined; the initiator must treat it like no request
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // Timeout settings walked through by the random part, defaults first and last.
  // The seventh entry is replaced by a random pair.
  localparam int NUM_SETTINGS = 8;
  localparam int RANDOM_SETTING = 6;
  localparam logic [3:0] DEV_SET [NUM_SETTINGS] =
    '{4'd4, 4'd1, 4'd15, 4'd0, 4'd1, 4'd15, 4'd4, 4'd4};
  localparam logic [3:0] TRDY_SET [NUM_SETTINGS] =
    '{4'd12, 4'd1, 4'd15, 4'd0, 4'd15, 4'd1, 4'd12, 4'd12};
  localparam int ITEMS_PER_SETTING = 178;

  // Cycles without any handshake before the run is declared hung
  localparam int HANG_LIMIT = 2000;

  // Transfer predictor plus the queue of bus cycles it expects back
  class xfer_scoreboard;
    phase_e      phase;
    logic [3:0]  wait_left;
    logic        is_wr;
    logic [3:0]  be_q;
    logic [31:0] word_q;
    logic        apar;
    logic [3:0]  devsel_to;
    logic [3:0]  trdy_to;
    res_t        exp_q[$];
    int          errors;
    int          results;
    int          status_cnt[8];

    function new();
      phase = PH_IDLE;
      wait_left = '0;
      is_wr = 1'b0;
      be_q = '0;
      word_q = '0;
      apar = 1'b0;
      devsel_to = DEVSEL_TO_RST;
      trdy_to = TRDY_TO_RST;
      errors = 0;
      results = 0;
      foreach (status_cnt[i]) status_cnt[i] = 0;
    endfunction

    function logic par_of(logic [31:0] w, logic [3:0] n);
      return ^{w, n};
    endfunction

    function logic [3:0] at_least_one(logic [3:0] t);
      return (t == 4'd0) ? 4'd1 : t;
    endfunction

    // IRDY asserted, FRAME released; write data or read turnaround on AD
    function void drive_wait(inout res_t o, input bit with_par);
      o.irdy_drive = 1'b1;
      if (is_wr) begin
        o.ad_out = word_q;
        o.ad_enable = 1'b1;
      end
      o.cbe_out = be_q;
      o.cbe_enable = 1'b1;
      if (with_par && is_wr) begin
        o.par_out = par_of(word_q, be_q);
        o.par_enable = 1'b1;
      end
    endfunction

    function void finish_xfer(inout res_t o, input logic [2:0] st, input logic [31:0] rd);
      o.done_res = 1'b1;
      o.status = st;
      o.read_data = rd;
      phase = PH_IDLE;
    endfunction

    function void trdy_clock(inout res_t o, input req_t r);
      if (r.trdy_seen) begin
        if (!is_wr) begin
          word_q = r.ad_sampled;
        end else begin
          o.par_out = par_of(word_q, be_q);
          o.par_enable = 1'b1;
        end
        phase = PH_POST;
      end else if (r.stop_seen) begin
        finish_xfer(o, r.devsel_seen ? ST_RETRY : ST_TARGET_ABORT, ALL_ONES);
      end else begin
        drive_wait(o, 1'b1);
        wait_left = wait_left - 4'd1;
        if (wait_left == 4'd0) phase = PH_ABORT_T;
      end
    endfunction

    // One bus clock: work out what the initiator drives next
    function void note_req(req_t r);
      res_t o;
      o = '0;
      case (phase)
        PH_IDLE: begin
          if (r.func == FUNC_READ || r.func == FUNC_WRITE) begin
            if (r.bus_busy_seen) begin
              finish_xfer(o, ST_BUS_ERR, ALL_ONES);
            end else begin
              is_wr = (r.func == FUNC_WRITE);
              be_q = r.byte_enables;
              word_q = is_wr ? r.write_data : 32'd0;
              apar = par_of(r.address, r.command);
              o.frame_drive = 1'b1;
              o.ad_out = r.address;
              o.ad_enable = 1'b1;
              o.cbe_out = r.command;
              o.cbe_enable = 1'b1;
              phase = PH_SETUP;
            end
          end
        end
        PH_SETUP: begin
          drive_wait(o, 1'b0);
          o.par_out = apar;
          o.par_enable = 1'b1;
          wait_left = at_least_one(devsel_to);
          phase = PH_DEVSEL;
        end
        PH_DEVSEL: begin
          if (!r.devsel_seen) begin
            drive_wait(o, 1'b1);
            wait_left = wait_left - 4'd1;
            if (wait_left == 4'd0) phase = PH_ABORT_M;
          end else begin
            // TRDY is looked at on the same clock that DEVSEL shows up
            wait_left = at_least_one(trdy_to);
            phase = PH_TRDY;
            trdy_clock(o, r);
          end
        end
        PH_TRDY: trdy_clock(o, r);
        PH_POST: begin
          if (is_wr) finish_xfer(o, ST_OK, 32'd0);
          else if (r.par_sampled != par_of(word_q, be_q)) finish_xfer(o, ST_PARITY_ERR, word_q);
          else finish_xfer(o, ST_OK, word_q);
        end
        PH_ABORT_M: finish_xfer(o, ST_MASTER_ABORT, ALL_ONES);
        PH_ABORT_T: finish_xfer(o, ST_TRDY_TIMEOUT, ALL_ONES);
        default: phase = PH_IDLE;
      endcase
      exp_q.push_back(o);
    endfunction

    function void check_field(string nm, logic [31:0] want_v, logic [31:0] got_v);
      if (got_v !== want_v) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, nm, want_v, got_v);
        errors++;
      end
    endfunction

    function void check_res(res_t got);
      res_t want;
      if (exp_q.size() == 0) begin
        $display("%0t: result %h with nothing expected", $time, got);
        errors++;
        return;
      end
      want = exp_q.pop_front();
      results++;
      if (want.done_res) status_cnt[want.status]++;
      check_field("frame_drive", 32'(want.frame_drive), 32'(got.frame_drive));
      check_field("irdy_drive", 32'(want.irdy_drive), 32'(got.irdy_drive));
      check_field("ad_out", want.ad_out, got.ad_out);
      check_field("ad_enable", 32'(want.ad_enable), 32'(got.ad_enable));
      check_field("cbe_out", 32'(want.cbe_out), 32'(got.cbe_out));
      check_field("cbe_enable", 32'(want.cbe_enable), 32'(got.cbe_enable));
      check_field("par_out", 32'(want.par_out), 32'(got.par_out));
      check_field("par_enable", 32'(want.par_enable), 32'(got.par_enable));
      check_field("done_res", 32'(want.done_res), 32'(got.done_res));
      check_field("status", 32'(want.status), 32'(got.status));
      check_field("read_data", want.read_data, got.read_data);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  req_t                 in_req = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  res_t                 out_res;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [3:0]           cfg_data = '0;

  xfer_scoreboard sb;

  // Target behavior, in percent, used while building each bus clock
  int dev_pct;         // DEVSEL while waiting for it
  int hold_pct;        // DEVSEL kept during the TRDY wait
  int trdy_pct;
  int stop_early_pct;  // STOP on the clock DEVSEL is awaited
  int stop_pct;        // STOP during the TRDY wait
  int parbad_pct;      // wrong PAR on the read parity clock
  int noise_pct;       // bus clock left fully random

  // Idle control for both sides; quiet turns all idling off
  int gap_pct = 0;
  int stall_pct = 0;
  bit quiet = 1'b0;
  int stall_left = 0;
  int idle_cycles = 0;
  int sent = 0;
  int settings_run = 1;

  pci_master_single_transfer u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_res_o   (out_res),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic bit chance(int p);
    return $urandom_range(99) < p;
  endfunction

  // Receiver: holds out_ready low in random stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= (stall_left == 1);
    end else if (!quiet && chance(stall_pct)) begin
      stall_left <= $urandom_range(1, 12);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Every accepted result is checked against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_res(out_res);
  end

  // Hang detection: any handshake restarts the count
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= HANG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic req_t rand_req();
    req_t r;
    r.func = 2'($urandom_range(3));
    r.address = $urandom;
    r.command = 4'($urandom_range(15));
    r.byte_enables = 4'($urandom_range(15));
    r.write_data = $urandom;
    r.devsel_seen = 1'($urandom_range(1));
    r.trdy_seen = 1'($urandom_range(1));
    r.stop_seen = 1'($urandom_range(1));
    r.bus_busy_seen = 1'($urandom_range(1));
    r.ad_sampled = $urandom;
    r.par_sampled = 1'($urandom_range(1));
    return r;
  endfunction

  // Bus clock shaped by the target knobs and the predicted phase
  function automatic req_t bus_item();
    req_t r;
    r = rand_req();
    if (!chance(noise_pct)) begin
      case (sb.phase)
        PH_DEVSEL: begin
          r.devsel_seen = chance(dev_pct);
          r.trdy_seen = chance(trdy_pct);
          r.stop_seen = chance(stop_early_pct);
        end
        PH_TRDY: begin
          r.devsel_seen = chance(hold_pct);
          r.trdy_seen = chance(trdy_pct);
          r.stop_seen = chance(stop_pct);
        end
        // read parity clock: correct PAR unless a bad one is asked for
        PH_POST: r.par_sampled = sb.par_of(sb.word_q, sb.be_q) ^ chance(parbad_pct);
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic set_target(input int dev, input int hold, input int trdy,
                            input int stop_early, input int stop, input int parbad,
                            input int noise);
    dev_pct = dev;
    hold_pct = hold;
    trdy_pct = trdy;
    stop_early_pct = stop_early;
    stop_pct = stop;
    parbad_pct = parbad;
    noise_pct = noise;
  endtask

  // Hand one bus clock to the block; valid stays up until it is taken
  task automatic send_item(input req_t r);
    if (!quiet && chance(gap_pct)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (!in_ready);
    sb.note_req(r);
    sent++;
  endtask

  // A request clock followed by bus clocks until the initiator is idle again
  task automatic transfer(input logic [1:0] f, input logic busy, input logic [31:0] addr,
                          input logic [31:0] wdata, input logic [3:0] cmd,
                          input logic [3:0] be);
    req_t r;
    r = rand_req();
    r.func = f;
    r.bus_busy_seen = busy;
    r.address = addr;
    r.write_data = wdata;
    r.command = cmd;
    r.byte_enables = be;
    send_item(r);
    while (sb.phase != PH_IDLE) send_item(bus_item());
  endtask

  task automatic random_transfer();
    logic [1:0] f;
    set_target(chance(10) ? 0 : $urandom_range(20, 100),
               $urandom_range(50, 100),
               chance(10) ? 0 : $urandom_range(10, 100),
               chance(20) ? $urandom_range(0, 50) : 0,
               chance(25) ? $urandom_range(0, 100) : 0,
               chance(20) ? 50 : 0,
               chance(10) ? 100 : $urandom_range(0, 10));
    if (chance(88)) f = $urandom_range(1) ? FUNC_WRITE : FUNC_READ;
    else f = $urandom_range(1) ? FUNC_NONE : FUNC_UNUSED;
    transfer(f, chance(8), $urandom, $urandom, 4'($urandom_range(15)),
             4'($urandom_range(15)));
  endtask

  // Drop valid, let every result come back, then a short pause
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.exp_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Both timeout registers back to back; valid stays high between them
  task automatic program_timeouts(input logic [3:0] dev_to, input logic [3:0] trdy_to);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_DEVSEL_TO;
    cfg_data <= dev_to;
    do @(posedge clk); while (!cfg_ready);
    sb.devsel_to = dev_to;
    cfg_index <= CFG_TRDY_TO;
    cfg_data <= trdy_to;
    do @(posedge clk); while (!cfg_ready);
    sb.trdy_to = trdy_to;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int target_cnt;
    logic [3:0] dev_to;
    logic [3:0] trdy_to;

    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed transfers at reset timeouts, no idling
    set_target(100, 100, 100, 0, 0, 0, 0);
    transfer(FUNC_READ, 1'b0, ALL_ONES, ALL_ONES, 4'hf, 4'hf);
    transfer(FUNC_WRITE, 1'b0, '0, '0, '0, '0);
    transfer(FUNC_WRITE, 1'b1, $urandom, $urandom, 4'h7, 4'h3);   // bus already busy
    transfer(FUNC_UNUSED, 1'b0, $urandom, $urandom, 4'h6, 4'hf);  // undefined request
    transfer(FUNC_NONE, 1'b0, $urandom, $urandom, 4'h6, 4'hf);
    // STOP with DEVSEL on the first target clock: retry
    set_target(100, 100, 0, 100, 0, 0, 0);
    transfer(FUNC_READ, 1'b0, $urandom, $urandom, 4'h6, 4'h0);
    // DEVSEL then STOP without it: target abort
    set_target(100, 0, 0, 0, 100, 0, 0);
    transfer(FUNC_WRITE, 1'b0, $urandom, $urandom, 4'h7, 4'h5);
    // bad PAR on the read data
    set_target(100, 100, 100, 0, 0, 100, 0);
    transfer(FUNC_READ, 1'b0, $urandom, $urandom, 4'h6, 4'ha);
    // nobody claims the cycle: master abort
    set_target(0, 0, 0, 0, 0, 0, 0);
    transfer(FUNC_WRITE, 1'b0, $urandom, $urandom, 4'h7, 4'hc);

    // Random transfers under each timeout setting; the last runs without idling
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      if (s > 0) begin
        dev_to = (s == RANDOM_SETTING) ? 4'($urandom_range(15)) : DEV_SET[s];
        trdy_to = (s == RANDOM_SETTING) ? 4'($urandom_range(15)) : TRDY_SET[s];
        settle();
        program_timeouts(dev_to, trdy_to);
        settings_run++;
      end
      quiet = (s == NUM_SETTINGS - 1);
      gap_pct = chance(25) ? 0 : $urandom_range(5, 40);
      stall_pct = chance(25) ? 0 : $urandom_range(5, 30);
      target_cnt = sent + ITEMS_PER_SETTING;
      while (sent < target_cnt) random_transfer();
    end

    settle();
    $display("Drove %0d bus clocks over %0d timeout settings, %0d results checked",
             sent, settings_run, sb.results);
    $display("Endings ok/mabort/tabort/trdy-to/retry/parity/busy: %0d/%0d/%0d/%0d/%0d/%0d/%0d",
             sb.status_cnt[ST_OK], sb.status_cnt[ST_MASTER_ABORT],
             sb.status_cnt[ST_TARGET_ABORT], sb.status_cnt[ST_TRDY_TIMEOUT],
             sb.status_cnt[ST_RETRY], sb.status_cnt[ST_PARITY_ERR], sb.status_cnt[ST_BUS_ERR]);
    if (sb.errors == 0 && sb.exp_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
